// ----- hdl/pfrf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrf_pkg: shared definitions for the page framebuffer rectangle fill block
// Screen geometry, item types, microcode control word and its program, and
// the mask and paint helpers used by the datapath.
// ----------------------------------------------------------------------------
package pfrf_pkg;

    localparam int SCREEN_COLUMNS  = 84;
    localparam int SCREEN_ROWS     = 48;
    localparam int STORE_PAGES     = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES     = SCREEN_COLUMNS * STORE_PAGES;
    localparam int RESET_ONES_FROM = (STORE_PAGES / 2) * SCREEN_COLUMNS;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
    localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
    localparam int PAGE_W = ROW_W - 3;

    localparam logic signed [16:0] COLS_WIDE = 17'(SCREEN_COLUMNS);
    localparam logic signed [16:0] ROWS_WIDE = 17'(SCREEN_ROWS);

    localparam logic [7:0] TOP_MASK [8] =
        '{8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE};
    localparam logic [7:0] BOTTOM_MASK [8] =
        '{8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F};
    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic [1:0] OPC_PIXEL = 2'd0;
    localparam logic [1:0] OPC_RECT  = 2'd1;
    localparam logic [1:0] OPC_CLEAR = 2'd2;
    localparam logic [1:0] OPC_READ  = 2'd3;

    localparam logic [1:0] COLOR_SET    = 2'd0;
    localparam logic [1:0] COLOR_CLEAR  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;
    localparam logic [1:0] COLOR_KEEP   = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
        logic [1:0]        color;
        logic [8:0]        read_address;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       is_read;
    } rsp_t;

    // Program steps
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] P_BOOT      = 4'd0;
    localparam logic [PC_W-1:0] P_BOOT_FILL = 4'd1;
    localparam logic [PC_W-1:0] P_IDLE      = 4'd2;
    localparam logic [PC_W-1:0] P_DECODE    = 4'd3;
    localparam logic [PC_W-1:0] P_CLASSIFY  = 4'd4;
    localparam logic [PC_W-1:0] P_CHECK     = 4'd5;
    localparam logic [PC_W-1:0] P_FETCH     = 4'd6;
    localparam logic [PC_W-1:0] P_MODIFY    = 4'd7;
    localparam logic [PC_W-1:0] P_NEXT_COL  = 4'd8;
    localparam logic [PC_W-1:0] P_DONE      = 4'd9;
    localparam logic [PC_W-1:0] P_READ      = 4'd10;
    localparam logic [PC_W-1:0] P_CLR       = 4'd11;
    localparam logic [PC_W-1:0] P_CLR_FILL  = 4'd12;

    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_ALWAYS     = 4'd1,
        C_IN_VALID   = 4'd2,
        C_OP_READ    = 4'd3,
        C_OP_CLEAR   = 4'd4,
        C_SKIP       = 4'd5,
        C_PAGE_MORE  = 4'd6,
        C_COL_MORE   = 4'd7,
        C_SWEEP_LAST = 4'd8,
        C_OUT_FREE   = 4'd9
    } cond_t;

    typedef enum logic [2:0] {
        ADDR_HOLD = 3'd0,
        ADDR_ZERO = 3'd1,
        ADDR_INC  = 3'd2,
        ADDR_SPAN = 3'd3,
        ADDR_PAGE = 3'd4,
        ADDR_COL  = 3'd5
    } addr_op_t;

    typedef enum logic [2:0] {
        MEM_NONE       = 3'd0,
        MEM_FETCH      = 3'd1,
        MEM_PAINT      = 3'd2,
        MEM_FILL_RESET = 3'd3,
        MEM_FILL_ZERO  = 3'd4,
        MEM_READ_ADDR  = 3'd5
    } mem_op_t;

    typedef struct packed {
        logic            take;
        logic            emit;
        logic            hold;
        cond_t           cond;
        logic [PC_W-1:0] target;
        addr_op_t        addr_op;
        mem_op_t         mem_op;
    } ctl_t;

    typedef struct packed {
        logic op_read;
        logic op_clear;
        logic skip;
        logic page_more;
        logic col_more;
        logic sweep_last;
    } status_t;

    function automatic ctl_t uword(input logic take, input logic emit, input logic hold,
                                   input cond_t cond, input logic [PC_W-1:0] target,
                                   input addr_op_t addr_op, input mem_op_t mem_op);
        ctl_t c;
        c.take    = take;
        c.emit    = emit;
        c.hold    = hold;
        c.cond    = cond;
        c.target  = target;
        c.addr_op = addr_op;
        c.mem_op  = mem_op;
        return c;
    endfunction

    // Control store: take, emit, hold, condition, jump target, address op, memory op
    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t c;
        unique case (pc)
            P_BOOT:      c = uword(1'b0, 1'b0, 1'b0, C_NEVER,      P_BOOT,
                               ADDR_ZERO, MEM_NONE);
            P_BOOT_FILL: c = uword(1'b0, 1'b0, 1'b1, C_SWEEP_LAST, P_IDLE,
                               ADDR_INC,  MEM_FILL_RESET);
            P_IDLE:      c = uword(1'b1, 1'b0, 1'b1, C_IN_VALID,   P_DECODE,
                               ADDR_HOLD, MEM_NONE);
            P_DECODE:    c = uword(1'b0, 1'b0, 1'b0, C_OP_READ,    P_READ,
                               ADDR_SPAN, MEM_NONE);
            P_CLASSIFY:  c = uword(1'b0, 1'b0, 1'b0, C_OP_CLEAR,   P_CLR,
                               ADDR_HOLD, MEM_NONE);
            P_CHECK:     c = uword(1'b0, 1'b0, 1'b0, C_SKIP,       P_DONE,
                               ADDR_HOLD, MEM_NONE);
            P_FETCH:     c = uword(1'b0, 1'b0, 1'b0, C_NEVER,      P_FETCH,
                               ADDR_HOLD, MEM_FETCH);
            P_MODIFY:    c = uword(1'b0, 1'b0, 1'b0, C_PAGE_MORE,  P_FETCH,
                               ADDR_PAGE, MEM_PAINT);
            P_NEXT_COL:  c = uword(1'b0, 1'b0, 1'b0, C_COL_MORE,   P_FETCH,
                               ADDR_COL,  MEM_NONE);
            P_DONE:      c = uword(1'b0, 1'b1, 1'b1, C_OUT_FREE,   P_IDLE,
                               ADDR_HOLD, MEM_NONE);
            P_READ:      c = uword(1'b0, 1'b0, 1'b0, C_ALWAYS,     P_DONE,
                               ADDR_HOLD, MEM_READ_ADDR);
            P_CLR:       c = uword(1'b0, 1'b0, 1'b0, C_NEVER,      P_CLR,
                               ADDR_ZERO, MEM_NONE);
            P_CLR_FILL:  c = uword(1'b0, 1'b0, 1'b1, C_SWEEP_LAST, P_DONE,
                               ADDR_INC,  MEM_FILL_ZERO);
            default:     c = uword(1'b0, 1'b0, 1'b0, C_ALWAYS,     P_BOOT,
                               ADDR_HOLD, MEM_NONE);
        endcase
        return c;
    endfunction

    function automatic logic signed [16:0] clamp17(input logic signed [16:0] v,
                                                   input logic signed [16:0] lim);
        if (v < 17'sd0)
            return 17'sd0;
        else if (v > lim)
            return lim;
        else
            return v;
    endfunction

    // Bits lo..hi of one page byte
    function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] first;
        logic [7:0] last;
        first = (lo == 3'd0) ? FULL_BYTE : TOP_MASK[3'(4'd8 - {1'b0, lo})];
        last  = (hi == 3'd7) ? FULL_BYTE : BOTTOM_MASK[hi + 3'd1];
        return first & last;
    endfunction

    function automatic logic [7:0] paint_byte(input logic [7:0] old, input logic [7:0] mask,
                                              input logic [1:0] color);
        logic [7:0] r;
        case (color)
            COLOR_SET:    r = old | mask;
            COLOR_CLEAR:  r = old & ~mask;
            COLOR_INVERT: r = old ^ mask;
            default:      r = old;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/page_framebuffer_rect_fill.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_rect_fill: monochrome page-layout framebuffer
// Pixel, rectangle, clear and byte read on an 84 x 48 store of page bytes.
// ----------------------------------------------------------------------------
// One item is handled at a time by a microcoded sequencer over a single-port
// frame store. After reset a clearing pass writes the power-up pattern, one
// byte a cycle, and cmd_ready stays low until it is done. Every page byte
// touched is read, then written back, and each column adds one more step to
// move to the next column. A finished result sits in an output register,
// so the next command is taken while the previous result is still waiting.
// ----------------------------------------------------------------------------
module page_framebuffer_rect_fill (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  pfrf_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pfrf_pkg::rsp_t  rsp
);

    pfrf_pkg::ctl_t    ctl;
    pfrf_pkg::status_t status;
    pfrf_pkg::rsp_t    result;
    pfrf_pkg::rsp_t    rsp_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              busy_reg,      busy_next;
    logic              out_free;
    logic              cmd_take;
    logic              rsp_load;

    assign cmd_ready = ctl.take;
    assign cmd_take  = cmd_valid && cmd_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_load  = ctl.emit && out_free;

    pfrf_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .cmd_valid (cmd_valid),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    pfrf_datapath u_dp (
        .clk       (clk),
        .ctl       (ctl),
        .take_item (cmd_take),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;

        busy_next = busy_reg;
        if (cmd_take)
            busy_next = 1'b1;
        else if (rsp_load)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            busy_reg      <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // one item in flight: no accept while busy, no result without an item
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> !busy_reg)
        else $error("command accepted while an item is still in flight");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> busy_reg)
        else $error("result produced with no item in flight");

    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> !cmd_ready)
        else $error("ready still high the cycle after an accept");

    a_draw_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_read |-> rsp.read_data == 8'h00)
        else $error("draw or clear result carries nonzero data");

endmodule

// ----- hdl/pfrf_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrf_sequencer: microcode step counter
// Reads one control word per step from the control store and picks the next
// step: jump target when the condition holds, else stay or fall through.
// ----------------------------------------------------------------------------
module pfrf_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  pfrf_pkg::status_t  status,
    input  logic               cmd_valid,
    input  logic               out_free,
    output pfrf_pkg::ctl_t     ctl
);

    logic [pfrf_pkg::PC_W-1:0] pc_reg;
    logic [pfrf_pkg::PC_W-1:0] pc_next;
    logic                      cond_true;

    assign ctl = pfrf_pkg::ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            pfrf_pkg::C_NEVER:      cond_true = 1'b0;
            pfrf_pkg::C_ALWAYS:     cond_true = 1'b1;
            pfrf_pkg::C_IN_VALID:   cond_true = cmd_valid;
            pfrf_pkg::C_OP_READ:    cond_true = status.op_read;
            pfrf_pkg::C_OP_CLEAR:   cond_true = status.op_clear;
            pfrf_pkg::C_SKIP:       cond_true = status.skip;
            pfrf_pkg::C_PAGE_MORE:  cond_true = status.page_more;
            pfrf_pkg::C_COL_MORE:   cond_true = status.col_more;
            pfrf_pkg::C_SWEEP_LAST: cond_true = status.sweep_last;
            pfrf_pkg::C_OUT_FREE:   cond_true = out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_true)
            pc_next = ctl.target;
        else if (ctl.hold)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= pfrf_pkg::P_BOOT;
        else
            pc_reg <= pc_next;
    end

endmodule

// ----- hdl/pfrf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfrf_datapath: clipping, address walk and frame store
// Latches the clipped extents of an item, walks page bytes column by column
// and does the read-modify-write on the single-port frame store.
// ----------------------------------------------------------------------------
module pfrf_datapath (
    input  logic               clk,
    input  pfrf_pkg::ctl_t     ctl,
    input  logic               take_item,
    input  pfrf_pkg::cmd_t     cmd,
    output pfrf_pkg::status_t  status,
    output pfrf_pkg::rsp_t     result
);

    localparam int AW = pfrf_pkg::ADDR_W;
    localparam int CW = pfrf_pkg::COL_W;
    localparam int RW = pfrf_pkg::ROW_W;
    localparam int PW = pfrf_pkg::PAGE_W;

    logic [7:0] mem [pfrf_pkg::STORE_BYTES];

    // item registers
    logic [1:0]    op_reg;
    logic [1:0]    color_reg;
    logic          read_ok_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [CW-1:0] xs_reg;
    logic [CW-1:0] xe_reg;
    logic [RW-1:0] ys_reg;
    logic [RW-1:0] ye_reg;

    // walk registers
    logic [CW-1:0] col_reg,        col_next;
    logic [AW-1:0] col_base_reg,   col_base_next;
    logic [AW-1:0] addr_reg,       addr_next;
    logic [PW-1:0] page_reg,       page_next;
    logic [PW-1:0] page_first_reg, page_first_next;
    logic [PW-1:0] page_last_reg,  page_last_next;
    logic [2:0]    lo_reg,         lo_next;
    logic [2:0]    hi_reg,         hi_next;
    logic [7:0]    rdata_reg;

    logic signed [15:0] w_eff;
    logic signed [15:0] h_eff;
    logic signed [16:0] x_end;
    logic signed [16:0] y_end;
    logic [RW-1:0]      y_last;
    logic [AW-1:0]      span_addr;
    logic [2:0]         m_lo;
    logic [2:0]         m_hi;
    logic [7:0]         mask;
    logic               wr_en;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_ptr;

    // a pixel is a one-by-one rectangle
    assign w_eff = (cmd.opcode == pfrf_pkg::OPC_PIXEL) ? 16'sd1 : cmd.rect_width;
    assign h_eff = (cmd.opcode == pfrf_pkg::OPC_PIXEL) ? 16'sd1 : cmd.rect_height;
    assign x_end = {cmd.x_pos[15], cmd.x_pos} + {w_eff[15], w_eff};
    assign y_end = {cmd.y_pos[15], cmd.y_pos} + {h_eff[15], h_eff};

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            op_reg      <= cmd.opcode;
            color_reg   <= cmd.color;
            read_ok_reg <= int'(cmd.read_address) < pfrf_pkg::STORE_BYTES;
            rd_addr_reg <= AW'(cmd.read_address);
            xs_reg <= CW'(pfrf_pkg::clamp17({cmd.x_pos[15], cmd.x_pos}, pfrf_pkg::COLS_WIDE));
            xe_reg <= CW'(pfrf_pkg::clamp17(x_end, pfrf_pkg::COLS_WIDE));
            ys_reg <= RW'(pfrf_pkg::clamp17({cmd.y_pos[15], cmd.y_pos}, pfrf_pkg::ROWS_WIDE));
            ye_reg <= RW'(pfrf_pkg::clamp17(y_end, pfrf_pkg::ROWS_WIDE));
        end
    end

    assign y_last    = ye_reg - RW'(1);
    assign span_addr = AW'(xs_reg)
                     + AW'(int'(ys_reg[RW-1:3]) * pfrf_pkg::SCREEN_COLUMNS);

    always_comb
    begin
        col_next        = col_reg;
        col_base_next   = col_base_reg;
        addr_next       = addr_reg;
        page_next       = page_reg;
        page_first_next = page_first_reg;
        page_last_next  = page_last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        unique case (ctl.addr_op)
            pfrf_pkg::ADDR_HOLD: ;
            pfrf_pkg::ADDR_ZERO: addr_next = '0;
            pfrf_pkg::ADDR_INC:  addr_next = addr_reg + 1'b1;
            pfrf_pkg::ADDR_SPAN:
            begin
                col_next        = xs_reg;
                col_base_next   = span_addr;
                addr_next       = span_addr;
                page_next       = ys_reg[RW-1:3];
                page_first_next = ys_reg[RW-1:3];
                page_last_next  = y_last[RW-1:3];
                lo_next         = ys_reg[2:0];
                hi_next         = y_last[2:0];
            end
            pfrf_pkg::ADDR_PAGE:
            begin
                if (status.page_more)
                begin
                    page_next = page_reg + 1'b1;
                    addr_next = addr_reg + AW'(pfrf_pkg::SCREEN_COLUMNS);
                end
            end
            pfrf_pkg::ADDR_COL:
            begin
                col_next      = col_reg + 1'b1;
                col_base_next = col_base_reg + 1'b1;
                addr_next     = col_base_reg + 1'b1;
                page_next     = page_first_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        col_base_reg   <= col_base_next;
        addr_reg       <= addr_next;
        page_reg       <= page_next;
        page_first_reg <= page_first_next;
        page_last_reg  <= page_last_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
    end

    // first and last page of a run are partial
    assign m_lo = (page_reg == page_first_reg) ? lo_reg : 3'd0;
    assign m_hi = (page_reg == page_last_reg) ? hi_reg : 3'd7;
    assign mask = pfrf_pkg::span_mask(m_lo, m_hi);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_ptr  = addr_reg;
        unique case (ctl.mem_op)
            pfrf_pkg::MEM_NONE: ;
            pfrf_pkg::MEM_FETCH: rd_en = 1'b1;
            pfrf_pkg::MEM_PAINT:
            begin
                wr_en   = 1'b1;
                wr_data = pfrf_pkg::paint_byte(rdata_reg, mask, color_reg);
            end
            pfrf_pkg::MEM_FILL_RESET:
            begin
                wr_en   = 1'b1;
                wr_data = (int'(addr_reg) >= pfrf_pkg::RESET_ONES_FROM) ?
                          pfrf_pkg::FULL_BYTE : 8'h00;
            end
            pfrf_pkg::MEM_FILL_ZERO: wr_en = 1'b1;
            pfrf_pkg::MEM_READ_ADDR:
            begin
                rd_en  = read_ok_reg;
                rd_ptr = rd_addr_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_reg] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_ptr];
    end

    assign status.op_read    = (op_reg == pfrf_pkg::OPC_READ);
    assign status.op_clear   = (op_reg == pfrf_pkg::OPC_CLEAR);
    assign status.skip       = (xs_reg >= xe_reg) || (ys_reg >= ye_reg)
                             || (color_reg == pfrf_pkg::COLOR_KEEP);
    assign status.page_more  = (page_reg != page_last_reg);
    assign status.col_more   = ({1'b0, col_reg} + 1'b1) < {1'b0, xe_reg};
    assign status.sweep_last = (addr_reg == AW'(pfrf_pkg::STORE_BYTES - 1));

    assign result.is_read   = (op_reg == pfrf_pkg::OPC_READ);
    assign result.read_data = ((op_reg == pfrf_pkg::OPC_READ) && read_ok_reg) ?
                              rdata_reg : 8'h00;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: page framebuffer rectangle fill
// Drives pixel, rectangle, clear and read commands with random gaps on both
// handshakes, tracks a shadow copy of the frame store and compares every
// reply with the reply that shadow predicts.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RUN_LIMIT_NS = 60_000_000;
    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE_CYCLES = 1200;

    class frame_scoreboard;
        logic [7:0]     shadow_frame [pfrf_pkg::STORE_BYTES];
        pfrf_pkg::rsp_t expected_replies [$];
        int             failures;

        function new();
            for (int i = 0; i < pfrf_pkg::STORE_BYTES; i++)
                shadow_frame[i] = (i < pfrf_pkg::RESET_ONES_FROM) ?
                                  8'h00 : pfrf_pkg::FULL_BYTE;
            failures = 0;
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction

        function void paint_bit(int col, int row, logic [1:0] color);
            int         idx;
            logic [7:0] bit_mask;
            idx = col + (row / 8) * pfrf_pkg::SCREEN_COLUMNS;
            bit_mask = 8'h01 << (row % 8);
            case (color)
                pfrf_pkg::COLOR_SET:    shadow_frame[idx] = shadow_frame[idx] | bit_mask;
                pfrf_pkg::COLOR_CLEAR:  shadow_frame[idx] = shadow_frame[idx] & ~bit_mask;
                pfrf_pkg::COLOR_INVERT: shadow_frame[idx] = shadow_frame[idx] ^ bit_mask;
                default:      ;
            endcase
        endfunction

        // Apply one command to the shadow store and queue the reply it owes
        function void note_command(pfrf_pkg::cmd_t c);
            pfrf_pkg::rsp_t reply;
            int   x;
            int   y;
            int   col_lo;
            int   col_hi;
            int   row_lo;
            int   row_cnt;
            x = c.x_pos;
            y = c.y_pos;
            reply = '0;
            case (c.opcode)
                pfrf_pkg::OPC_PIXEL:
                    if (x >= 0 && x < pfrf_pkg::SCREEN_COLUMNS &&
                        y >= 0 && y < pfrf_pkg::SCREEN_ROWS)
                        paint_bit(x, y, c.color);
                pfrf_pkg::OPC_RECT:
                begin
                    // Sums are taken at full precision, no 16-bit wrap
                    col_lo = (x < 0) ? 0 : x;
                    col_hi = x + int'(c.rect_width);
                    if (col_hi > pfrf_pkg::SCREEN_COLUMNS)
                        col_hi = pfrf_pkg::SCREEN_COLUMNS;
                    row_lo = y;
                    row_cnt = c.rect_height;
                    if (row_lo < 0)
                    begin
                        row_cnt += row_lo;
                        row_lo = 0;
                    end
                    if (row_lo + row_cnt > pfrf_pkg::SCREEN_ROWS)
                        row_cnt = pfrf_pkg::SCREEN_ROWS - row_lo;
                    for (int col = col_lo; col < col_hi; col++)
                        for (int row = row_lo; row < row_lo + row_cnt; row++)
                            paint_bit(col, row, c.color);
                end
                pfrf_pkg::OPC_CLEAR:
                    for (int i = 0; i < pfrf_pkg::STORE_BYTES; i++)
                        shadow_frame[i] = 8'h00;
                default:
                begin
                    reply.is_read = 1'b1;
                    if (c.read_address < pfrf_pkg::STORE_BYTES)
                        reply.read_data = shadow_frame[c.read_address];
                end
            endcase
            expected_replies.push_back(reply);
        endfunction

        function void check_reply(pfrf_pkg::rsp_t got);
            pfrf_pkg::rsp_t want;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: reply with none pending, read_data %02h is_read %0b",
                         $time, got.read_data, got.is_read);
                failures++;
                return;
            end
            want = expected_replies.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $display("%0t: read_data expected %02h actual %02h",
                         $time, want.read_data, got.read_data);
                failures++;
            end
            if (got.is_read !== want.is_read)
            begin
                $display("%0t: is_read expected %0b actual %0b",
                         $time, want.is_read, got.is_read);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    pfrf_pkg::cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    pfrf_pkg::rsp_t rsp;

    frame_scoreboard scb;
    bit              quiet = 1'b0;
    int              ready_hold = 0;

    page_framebuffer_rect_fill dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic pfrf_pkg::cmd_t make_cmd(logic [1:0] op, int x, int y, int w, int h,
                                                logic [1:0] color, int addr);
        pfrf_pkg::cmd_t c;
        c.opcode = op;
        c.x_pos = 16'(x);
        c.y_pos = 16'(y);
        c.rect_width = 16'(w);
        c.rect_height = 16'(h);
        c.color = color;
        c.read_address = 9'(addr);
        return c;
    endfunction

    function automatic int pick_extent(int near_lo, int near_hi, int far_hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return int'(16'($urandom) - 17'sd0) - (($urandom_range(0, 1) == 1) ? 65536 : 0);
        else if (roll == 1)
            return $urandom_range(0, far_hi);
        else
            return $urandom_range(0, near_hi - near_lo) + near_lo;
    endfunction

    // Mostly on-screen geometry, with some full-range noise on every position and extent
    function automatic pfrf_pkg::cmd_t random_cmd();
        pfrf_pkg::cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            c.opcode = pfrf_pkg::OPC_CLEAR;
        else if (pick < 33)
            c.opcode = pfrf_pkg::OPC_PIXEL;
        else if (pick < 63)
            c.opcode = pfrf_pkg::OPC_RECT;
        else
            c.opcode = pfrf_pkg::OPC_READ;
        c.color = ($urandom_range(0, 9) == 0) ? pfrf_pkg::COLOR_KEEP :
                  2'($urandom_range(0, 2));
        c.x_pos = 16'(pick_extent(-8, pfrf_pkg::SCREEN_COLUMNS + 7,
                                  pfrf_pkg::SCREEN_COLUMNS + 20));
        c.y_pos = 16'(pick_extent(-8, pfrf_pkg::SCREEN_ROWS + 7,
                                  pfrf_pkg::SCREEN_ROWS + 20));
        c.rect_width = 16'(pick_extent(-2, 12, pfrf_pkg::SCREEN_COLUMNS + 6));
        c.rect_height = 16'(pick_extent(-2, 14, pfrf_pkg::SCREEN_ROWS + 6));
        if ($urandom_range(0, 15) == 0)
            c.read_address = 9'($urandom_range(pfrf_pkg::STORE_BYTES, 511));
        else
            c.read_address = 9'($urandom_range(0, pfrf_pkg::STORE_BYTES - 1));
        return c;
    endfunction

    task automatic issue(input pfrf_pkg::cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        scb.note_command(c);
    endtask

    // Hold off new items until every reply is back
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (scb.outstanding() > 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                scb.check_reply(rsp);
                ready_hold = pick_gap();
            end
            else if (ready_hold > 0)
                ready_hold--;
            rsp_ready <= (ready_hold == 0);
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        scb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Power-up pattern, then pixel edges and clipping
        issue(make_cmd(pfrf_pkg::OPC_READ, 0, 0, 0, 0, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_READ, 0, 0, 0, 0, pfrf_pkg::COLOR_SET,
                       pfrf_pkg::RESET_ONES_FROM));
        issue(make_cmd(pfrf_pkg::OPC_READ, 0, 0, 0, 0, pfrf_pkg::COLOR_SET,
                       pfrf_pkg::STORE_BYTES - 1));
        issue(make_cmd(pfrf_pkg::OPC_READ, 0, 0, 0, 0, pfrf_pkg::COLOR_SET, 511));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, 0, 0, 0, 0, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, pfrf_pkg::SCREEN_COLUMNS - 1,
                       pfrf_pkg::SCREEN_ROWS - 1, 0, 0, pfrf_pkg::COLOR_CLEAR, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, pfrf_pkg::SCREEN_COLUMNS - 1, 40, 0, 0,
                       pfrf_pkg::COLOR_INVERT, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, 1, 0, 0, 0, pfrf_pkg::COLOR_KEEP, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, -1, 0, 0, 0, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, pfrf_pkg::SCREEN_COLUMNS, 0, 0, 0,
                       pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, 0, pfrf_pkg::SCREEN_ROWS, 0, 0,
                       pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_PIXEL, 32767, -32768, -1, -1,
                       pfrf_pkg::COLOR_INVERT, 511));
        // Rectangles: wide sums, clipping, partial bytes, empty extents; then clear and read back
        issue(make_cmd(pfrf_pkg::OPC_RECT, -32768, 0, 32767, 10, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 32767, 0, 32767, 10, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, -5, -5, 10, 10, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 10, 3, 3, 2, pfrf_pkg::COLOR_INVERT, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 20, 5, 4, 20, pfrf_pkg::COLOR_CLEAR, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 30, 10, 0, 10, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 30, 10, 5, -5, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 5, -32768, 3, 32767, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 0, 0, pfrf_pkg::SCREEN_COLUMNS,
                       pfrf_pkg::SCREEN_ROWS, pfrf_pkg::COLOR_INVERT, 0));
        issue(make_cmd(pfrf_pkg::OPC_RECT, 0, 0, pfrf_pkg::SCREEN_COLUMNS,
                       pfrf_pkg::SCREEN_ROWS, pfrf_pkg::COLOR_KEEP, 0));
        issue(make_cmd(pfrf_pkg::OPC_READ, 0, 0, 0, 0, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_CLEAR, 0, 0, 0, 0, pfrf_pkg::COLOR_SET, 0));
        issue(make_cmd(pfrf_pkg::OPC_READ, 0, 0, 0, 0, pfrf_pkg::COLOR_SET,
                       pfrf_pkg::RESET_ONES_FROM));
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain();
            issue(random_cmd());
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (scb.failures == 0 && scb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
